// File: design/pbc_pkg.sv
// Package for the polygon box clipper: sequencer states, divider phases,
// configuration register indexes and fixed constants. No dependencies.
`default_nettype none

package pbc_pkg;

  // clip planes in order: x min, x max, y min, y max, z min, z max
  localparam int NUM_STAGES = 6;
  // stage level, 0..NUM_STAGES (NUM_STAGES means "goes to output")
  localparam int LVL_W = 3;
  // width of the output limit and the per-polygon emit counter
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] MAX_OUT_RESET = 16'd1024;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN   = 3'd0,
    CFG_X_MAX   = 3'd1,
    CFG_Y_MIN   = 3'd2,
    CFG_Y_MAX   = 3'd3,
    CFG_Z_MIN   = 3'd4,
    CFG_Z_MAX   = 3'd5,
    CFG_MAX_OUT = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT,
    ST_POP,
    ST_CLOSE,
    ST_FIN
  } seq_state_e;

  typedef enum logic {
    PH_MUL,
    PH_DIV
  } div_phase_e;

endpackage

`default_nettype wire

// File: design/pbc_if.sv
// Valid/ready channel interfaces for the polygon box clipper: vertex input
// and clipped vertex output. No dependencies.
`default_nettype none

interface pbc_in_if #(parameter int COORD_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vx;
  logic [COORD_BITS-1:0] vy;
  logic [COORD_BITS-1:0] vz;
  logic                  last_vertex;

  modport source (output valid, vx, vy, vz, last_vertex, input ready);
  modport sink   (input valid, vx, vy, vz, last_vertex, output ready);
endinterface

interface pbc_out_if #(parameter int COORD_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] ox;
  logic [COORD_BITS-1:0] oy;
  logic [COORD_BITS-1:0] oz;
  logic                  vertex_valid;
  logic                  run_last;
  logic                  polygon_done;
  logic                  overflow;

  modport source (output valid, ox, oy, oz, vertex_valid, run_last, polygon_done,
                  overflow, input ready);
  modport sink   (input valid, ox, oy, oz, vertex_valid, run_last, polygon_done,
                  overflow, output ready);
endinterface

`default_nettype wire

// File: design/polygon_box_clipper.sv
// A vertex keeps the block busy from its accepting edge until it is dropped or
// fully processed, and longer under output stalls; every crossing runs its x, y
// and z interpolations in the shared serial divider. One vertex at a time: ready
// is high only in the idle state between vertices. Output beats pass through a
// hold register and an output register. Reset (rst_ni low, async): box bounds 0,
// max_output 1024, polygon cleared. Depends on pbc_pkg, pbc_if and pbc_xdiv.
`default_nettype none

module polygon_box_clipper #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pbc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]               cfg_data_i,
  pbc_in_if.sink                                   in_ch,
  pbc_out_if.source                                out_ch
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int NS = pbc_pkg::NUM_STAGES;
  localparam int LW = pbc_pkg::LVL_W;
  localparam int KW = pbc_pkg::CNT_W;

  // configuration
  logic [CB-1:0] xmin_q, xmax_q, ymin_q, ymax_q, zmin_q, zmax_q;
  logic [KW-1:0] maxo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= '0;
      xmax_q <= '0;
      ymin_q <= '0;
      ymax_q <= '0;
      zmin_q <= '0;
      zmax_q <= '0;
      maxo_q <= pbc_pkg::MAX_OUT_RESET;
    end else if (cfg_we_i) begin
      unique case (pbc_pkg::cfg_reg_e'(cfg_idx_i))
        pbc_pkg::CFG_X_MIN:   xmin_q <= cfg_data_i;
        pbc_pkg::CFG_X_MAX:   xmax_q <= cfg_data_i;
        pbc_pkg::CFG_Y_MIN:   ymin_q <= cfg_data_i;
        pbc_pkg::CFG_Y_MAX:   ymax_q <= cfg_data_i;
        pbc_pkg::CFG_Z_MIN:   zmin_q <= cfg_data_i;
        pbc_pkg::CFG_Z_MAX:   zmax_q <= cfg_data_i;
        pbc_pkg::CFG_MAX_OUT: maxo_q <= cfg_data_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  pbc_pkg::seq_state_e state_q, state_d;
  logic [LW-1:0] lv_q, lv_d, cp_q, cp_d;
  logic          last_q, last_d;
  logic [NS-1:0] started_q, started_d;
  logic [NS-1:0] pv_q, pv_d;
  logic [KW-1:0] emitted_q, emitted_d;
  logic          drop_q, drop_d;
  logic          hold_v_q, hold_v_d;
  logic          out_v_q, out_v_d;
  logic [1:0]    k_q, k_d;

  // payload state
  logic [CB-1:0] cur_x_q, cur_y_q, cur_z_q, cur_x_d, cur_y_d, cur_z_d;
  logic [CB-1:0] first_x_q [NS], first_y_q [NS], first_z_q [NS];
  logic [CB-1:0] first_x_d [NS], first_y_d [NS], first_z_d [NS];
  logic [DW-1:0] first_dq [NS], first_dd [NS];
  logic [CB-1:0] prev_x_q [NS], prev_y_q [NS], prev_z_q [NS];
  logic [CB-1:0] prev_x_d [NS], prev_y_d [NS], prev_z_d [NS];
  logic [DW-1:0] prev_dq [NS], prev_dd [NS];
  logic [CB-1:0] px_q [NS], py_q [NS], pz_q [NS];
  logic [CB-1:0] px_d [NS], py_d [NS], pz_d [NS];
  logic [CB-1:0] oa_x_q, oa_y_q, oa_z_q, ob_x_q, ob_y_q, ob_z_q;
  logic [CB-1:0] oa_x_d, oa_y_d, oa_z_d, ob_x_d, ob_y_d, ob_z_d;
  logic [DW-1:0] oda_q, odb_q, oda_d, odb_d;
  logic [CB-1:0] hx_q, hy_q, hz_q, hx_d, hy_d, hz_d;
  logic          hvv_q, hovf_q, hvv_d, hovf_d;
  logic [CB-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic          ovv_q, orl_q, opd_q, oovf_q, ovv_d, orl_d, opd_d, oovf_d;

  // divider hookup
  logic          div_start, div_done;
  logic [CB-1:0] div_c0, div_c1, div_res;

  function automatic logic crosses(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic a_pos, b_pos;
    a_pos = !a[DW-1] && (a != '0);
    b_pos = !b[DW-1] && (b != '0);
    return (a[DW-1] && b_pos) || (a_pos && b[DW-1]);
  endfunction

  // signed distance of the current vertex to plane lv
  logic signed [DW-1:0] dcur;
  always_comb begin
    unique case (lv_q)
      LW'(0):  dcur = $signed({cur_x_q[CB-1], cur_x_q}) - $signed({xmin_q[CB-1], xmin_q});
      LW'(1):  dcur = $signed({xmax_q[CB-1], xmax_q}) - $signed({cur_x_q[CB-1], cur_x_q});
      LW'(2):  dcur = $signed({cur_y_q[CB-1], cur_y_q}) - $signed({ymin_q[CB-1], ymin_q});
      LW'(3):  dcur = $signed({ymax_q[CB-1], ymax_q}) - $signed({cur_y_q[CB-1], cur_y_q});
      LW'(4):  dcur = $signed({cur_z_q[CB-1], cur_z_q}) - $signed({zmin_q[CB-1], zmin_q});
      default: dcur = $signed({zmax_q[CB-1], zmax_q}) - $signed({cur_z_q[CB-1], cur_z_q});
    endcase
  end

  // deepest pending vertex (stack top)
  logic          pop_found;
  logic [LW-1:0] pop_k;
  always_comb begin
    pop_found = 1'b0;
    pop_k     = '0;
    for (int i = 0; i < NS; i++) begin
      if (pv_q[i]) begin
        pop_found = 1'b1;
        pop_k     = LW'(i);
      end
    end
  end

  logic out_free;
  assign out_free = !out_v_q || out_ch.ready;

  // sequencer: next state and register updates
  always_comb begin
    state_d   = state_q;
    lv_d      = lv_q;
    cp_d      = cp_q;
    last_d    = last_q;
    started_d = started_q;
    pv_d      = pv_q;
    emitted_d = emitted_q;
    drop_d    = drop_q;
    hold_v_d  = hold_v_q;
    out_v_d   = out_v_q && !out_ch.ready;
    k_d       = k_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    cur_z_d   = cur_z_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    first_z_d = first_z_q;
    first_dd  = first_dq;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    prev_z_d  = prev_z_q;
    prev_dd   = prev_dq;
    px_d      = px_q;
    py_d      = py_q;
    pz_d      = pz_q;
    oa_x_d    = oa_x_q;
    oa_y_d    = oa_y_q;
    oa_z_d    = oa_z_q;
    ob_x_d    = ob_x_q;
    ob_y_d    = ob_y_q;
    ob_z_d    = ob_z_q;
    oda_d     = oda_q;
    odb_d     = odb_q;
    hx_d      = hx_q;
    hy_d      = hy_q;
    hz_d      = hz_q;
    hvv_d     = hvv_q;
    hovf_d    = hovf_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oz_d      = oz_q;
    ovv_d     = ovv_q;
    orl_d     = orl_q;
    opd_d     = opd_q;
    oovf_d    = oovf_q;

    unique case (state_q)
      pbc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          cur_x_d = in_ch.vx;
          cur_y_d = in_ch.vy;
          cur_z_d = in_ch.vz;
          last_d  = in_ch.last_vertex;
          lv_d    = '0;
          cp_d    = '0;
          state_d = drop_q ? pbc_pkg::ST_FIN : pbc_pkg::ST_PROC;
        end
      end

      pbc_pkg::ST_PROC: begin
        if (lv_q == LW'(NS)) begin
          state_d = pbc_pkg::ST_EMIT;
        end else begin
          if (!started_q[lv_q]) begin
            started_d[lv_q] = 1'b1;
            first_x_d[lv_q] = cur_x_q;
            first_y_d[lv_q] = cur_y_q;
            first_z_d[lv_q] = cur_z_q;
            first_dd[lv_q]  = dcur;
          end
          prev_x_d[lv_q] = cur_x_q;
          prev_y_d[lv_q] = cur_y_q;
          prev_z_d[lv_q] = cur_z_q;
          prev_dd[lv_q]  = dcur;
          if (started_q[lv_q] && crosses(prev_dq[lv_q], dcur)) begin
            // crossing goes first; an inside vertex waits on the stack
            oa_x_d = prev_x_q[lv_q];
            oa_y_d = prev_y_q[lv_q];
            oa_z_d = prev_z_q[lv_q];
            ob_x_d = cur_x_q;
            ob_y_d = cur_y_q;
            ob_z_d = cur_z_q;
            oda_d  = prev_dq[lv_q];
            odb_d  = dcur;
            k_d    = '0;
            if (!dcur[DW-1]) begin
              pv_d[lv_q] = 1'b1;
              px_d[lv_q] = cur_x_q;
              py_d[lv_q] = cur_y_q;
              pz_d[lv_q] = cur_z_q;
            end
            lv_d    = lv_q + 1'b1;
            state_d = pbc_pkg::ST_DSTART;
          end else if (!dcur[DW-1]) begin
            lv_d = lv_q + 1'b1;
          end else begin
            state_d = pbc_pkg::ST_POP;
          end
        end
      end

      pbc_pkg::ST_DSTART: begin
        state_d = pbc_pkg::ST_DWAIT;
      end

      pbc_pkg::ST_DWAIT: begin
        if (div_done) begin
          unique case (k_q)
            2'd0:    cur_x_d = div_res;
            2'd1:    cur_y_d = div_res;
            default: cur_z_d = div_res;
          endcase
          if (k_q == 2'd2) begin
            state_d = pbc_pkg::ST_PROC;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = pbc_pkg::ST_DSTART;
          end
        end
      end

      pbc_pkg::ST_EMIT: begin
        if (!hold_v_q || out_free) begin
          // the held beat is not the last one of this vertex
          if (hold_v_q) begin
            ox_d    = hx_q;
            oy_d    = hy_q;
            oz_d    = hz_q;
            ovv_d   = hvv_q;
            oovf_d  = hovf_q;
            orl_d   = 1'b0;
            opd_d   = 1'b0;
            out_v_d = 1'b1;
          end
          hold_v_d = 1'b1;
          if (emitted_q >= maxo_q) begin
            // rest of the item is dropped, stacked vertices too
            hx_d    = '0;
            hy_d    = '0;
            hz_d    = '0;
            hvv_d   = 1'b0;
            hovf_d  = 1'b1;
            drop_d  = 1'b1;
            pv_d    = '0;
            state_d = pbc_pkg::ST_FIN;
          end else begin
            hx_d      = cur_x_q;
            hy_d      = cur_y_q;
            hz_d      = cur_z_q;
            hvv_d     = 1'b1;
            hovf_d    = 1'b0;
            emitted_d = emitted_q + 1'b1;
            state_d   = pbc_pkg::ST_POP;
          end
        end
      end

      pbc_pkg::ST_POP: begin
        if (pop_found) begin
          pv_d[pop_k] = 1'b0;
          cur_x_d     = px_q[pop_k];
          cur_y_d     = py_q[pop_k];
          cur_z_d     = pz_q[pop_k];
          lv_d        = pop_k + 1'b1;
          state_d     = pbc_pkg::ST_PROC;
        end else if (last_q) begin
          state_d = pbc_pkg::ST_CLOSE;
        end else begin
          state_d = pbc_pkg::ST_FIN;
        end
      end

      pbc_pkg::ST_CLOSE: begin
        if (cp_q == LW'(NS)) begin
          state_d = pbc_pkg::ST_FIN;
        end else if (!started_q[cp_q]) begin
          state_d = pbc_pkg::ST_FIN;
        end else begin
          // closing edge from previous back to first vertex
          prev_x_d[cp_q] = first_x_q[cp_q];
          prev_y_d[cp_q] = first_y_q[cp_q];
          prev_z_d[cp_q] = first_z_q[cp_q];
          prev_dd[cp_q]  = first_dq[cp_q];
          cp_d           = cp_q + 1'b1;
          if (crosses(prev_dq[cp_q], first_dq[cp_q])) begin
            oa_x_d  = prev_x_q[cp_q];
            oa_y_d  = prev_y_q[cp_q];
            oa_z_d  = prev_z_q[cp_q];
            ob_x_d  = first_x_q[cp_q];
            ob_y_d  = first_y_q[cp_q];
            ob_z_d  = first_z_q[cp_q];
            oda_d   = prev_dq[cp_q];
            odb_d   = first_dq[cp_q];
            k_d     = '0;
            lv_d    = cp_q + 1'b1;
            state_d = pbc_pkg::ST_DSTART;
          end
        end
      end

      pbc_pkg::ST_FIN: begin
        if (out_free) begin
          if (hold_v_q) begin
            ox_d     = hx_q;
            oy_d     = hy_q;
            oz_d     = hz_q;
            ovv_d    = hvv_q;
            oovf_d   = hovf_q;
            orl_d    = 1'b1;
            opd_d    = last_q;
            out_v_d  = 1'b1;
            hold_v_d = 1'b0;
          end else if (last_q) begin
            // closing beat with no vertex
            ox_d    = '0;
            oy_d    = '0;
            oz_d    = '0;
            ovv_d   = 1'b0;
            oovf_d  = 1'b0;
            orl_d   = 1'b1;
            opd_d   = 1'b1;
            out_v_d = 1'b1;
          end
          if (last_q) begin
            started_d = '0;
            emitted_d = '0;
            drop_d    = 1'b0;
          end
          state_d = pbc_pkg::ST_IDLE;
        end
      end

      default: state_d = pbc_pkg::ST_IDLE;
    endcase
  end

  // handshake and divider control
  always_comb begin
    in_ch.ready = (state_q == pbc_pkg::ST_IDLE);
    div_start   = (state_q == pbc_pkg::ST_DSTART);
    unique case (k_q)
      2'd0: begin
        div_c0 = oa_x_q;
        div_c1 = ob_x_q;
      end
      2'd1: begin
        div_c0 = oa_y_q;
        div_c1 = ob_y_q;
      end
      default: begin
        div_c0 = oa_z_q;
        div_c1 = ob_z_q;
      end
    endcase
  end

  pbc_xdiv #(
    .COORD_BITS (CB)
  ) u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .c0_i    (div_c0),
    .c1_i    (div_c1),
    .da_i    (oda_q),
    .db_i    (odb_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pbc_pkg::ST_IDLE;
      lv_q      <= '0;
      cp_q      <= '0;
      last_q    <= 1'b0;
      started_q <= '0;
      pv_q      <= '0;
      emitted_q <= '0;
      drop_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      lv_q      <= lv_d;
      cp_q      <= cp_d;
      last_q    <= last_d;
      started_q <= started_d;
      pv_q      <= pv_d;
      emitted_q <= emitted_d;
      drop_q    <= drop_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
      k_q       <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    cur_z_q   <= cur_z_d;
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    first_z_q <= first_z_d;
    first_dq  <= first_dd;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    prev_z_q  <= prev_z_d;
    prev_dq   <= prev_dd;
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    oa_x_q    <= oa_x_d;
    oa_y_q    <= oa_y_d;
    oa_z_q    <= oa_z_d;
    ob_x_q    <= ob_x_d;
    ob_y_q    <= ob_y_d;
    ob_z_q    <= ob_z_d;
    oda_q     <= oda_d;
    odb_q     <= odb_d;
    hx_q      <= hx_d;
    hy_q      <= hy_d;
    hz_q      <= hz_d;
    hvv_q     <= hvv_d;
    hovf_q    <= hovf_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    oz_q      <= oz_d;
    ovv_q     <= ovv_d;
    orl_q     <= orl_d;
    opd_q     <= opd_d;
    oovf_q    <= oovf_d;
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.ox           = ox_q;
  assign out_ch.oy           = oy_q;
  assign out_ch.oz           = oz_q;
  assign out_ch.vertex_valid = ovv_q;
  assign out_ch.run_last     = orl_q;
  assign out_ch.polygon_done = opd_q;
  assign out_ch.overflow     = oovf_q;

  // a stage only starts after the one before it has
  a_started_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((started_q >> 1) & ~started_q) == '0)
    else $error("stage started ahead of its predecessor");

  // no held beat or stacked vertex survives between vertices
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbc_pkg::ST_IDLE) |-> (!hold_v_q && pv_q == '0))
    else $error("leftover work while idle");

  // overflow beat never carries a vertex
  a_ovf_novtx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && oovf_q) |-> !ovv_q)
    else $error("overflow beat with vertex");

  // closing pointer and stage level stay in range
  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_q <= LW'(NS) && lv_q <= LW'(NS))
    else $error("stage index out of range");

endmodule

`default_nettype wire

// File: design/pbc_xdiv.sv
// Serial crossing unit: c0 + trunc(da*(c1-c0)/(da-db)) by shift-add multiply
// then restoring divide, one bit per cycle. Depends on pbc_pkg.
`default_nettype none

module pbc_xdiv #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] c0_i,
  input  wire logic [COORD_BITS-1:0] c1_i,
  input  wire logic [COORD_BITS:0]   da_i,
  input  wire logic [COORD_BITS:0]   db_i,
  output logic                       done_o,
  output logic [COORD_BITS-1:0]      res_o
);

  localparam int CB = COORD_BITS;
  localparam int N  = CB + 1;        // magnitude / quotient bits
  localparam int PW = 2 * N;         // product bits
  localparam int CW = $clog2(N);

  logic                 busy_q;
  pbc_pkg::div_phase_e  ph_q;
  logic [CW-1:0]        cnt_q;
  logic [N-1:0]         a_q, b_q;
  logic [N:0]           d_q, rem_q;
  logic [PW-1:0]        acc_q;
  logic                 neg_q;
  logic [CB-1:0]        c0_q;
  logic                 done_q;
  logic [CB-1:0]        res_q;

  // operand setup
  logic signed [N-1:0] diff;
  logic signed [N:0]   den;
  logic [N-1:0]        a_mag, b_mag;
  logic [N:0]          d_mag;
  logic                neg;

  always_comb begin
    diff  = $signed({c1_i[CB-1], c1_i}) - $signed({c0_i[CB-1], c0_i});
    den   = $signed({da_i[N-1], da_i}) - $signed({db_i[N-1], db_i});
    a_mag = da_i[N-1] ? N'(-da_i) : da_i;
    b_mag = diff[N-1] ? N'(-diff) : N'(diff);
    d_mag = den[N] ? (N+1)'(-den) : (N+1)'(den);
    neg   = da_i[N-1] ^ diff[N-1] ^ den[N];
  end

  // one step of multiply or divide
  logic [PW-1:0]  acc_d;
  logic [N+1:0]   trial;
  logic           ge;
  logic [N:0]     rem_d;
  logic [N-1:0]   quo;
  logic [N:0]     sum;

  always_comb begin
    acc_d = {acc_q[PW-2:0], 1'b0} + (b_q[N-1] ? PW'(a_q) : '0);
    trial = {rem_q, b_q[N-1]};
    ge    = trial >= {1'b0, d_q};
    rem_d = ge ? (N+1)'(trial - {1'b0, d_q}) : (N+1)'(trial);
    quo   = {b_q[N-2:0], ge};
    sum   = neg_q ? {c0_q[CB-1], c0_q[CB-1], c0_q} - {1'b0, quo}
                  : {c0_q[CB-1], c0_q[CB-1], c0_q} + {1'b0, quo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= pbc_pkg::PH_MUL;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= pbc_pkg::PH_MUL;
        cnt_q  <= CW'(N - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          if (ph_q == pbc_pkg::PH_MUL) begin
            ph_q  <= pbc_pkg::PH_DIV;
            cnt_q <= CW'(N - 1);
          end else begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag;
      b_q   <= b_mag;
      d_q   <= d_mag;
      neg_q <= neg;
      c0_q  <= c0_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (ph_q == pbc_pkg::PH_MUL) begin
        acc_q <= acc_d;
        if (cnt_q == '0) begin
          rem_q <= {1'b0, acc_d[PW-1:N]};
          b_q   <= acc_d[N-1:0];
        end else begin
          b_q <= {b_q[N-2:0], 1'b0};
        end
      end else begin
        rem_q <= rem_d;
        b_q   <= quo;
        if (cnt_q == '0) begin
          res_q <= sum[CB-1:0];
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
